// ----- sv/att_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package att_pkg;

    // fixed widths of the datapath
    localparam int AXIS_W    = 10;
    localparam int PRE_SHIFT = 20;
    localparam int VEC_W     = 34;
    localparam int ACC_FRAC  = 16;
    localparam int ACC_W     = 26;
    localparam int TABLE_LEN = 24;
    localparam int ANGLE_W   = 15;
    localparam int TILT_W    = 16;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // atan(2^-i) in units of 2^-16 degree
    function automatic acc_t atan_entry(input logic [4:0] idx);
        acc_t v;
        begin
            v = '0;
            case (idx)
                5'd0:  v = 26'sd2949120;
                5'd1:  v = 26'sd1740967;
                5'd2:  v = 26'sd919879;
                5'd3:  v = 26'sd466945;
                5'd4:  v = 26'sd234379;
                5'd5:  v = 26'sd117304;
                5'd6:  v = 26'sd58666;
                5'd7:  v = 26'sd29335;
                5'd8:  v = 26'sd14668;
                5'd9:  v = 26'sd7334;
                5'd10: v = 26'sd3667;
                5'd11: v = 26'sd1833;
                5'd12: v = 26'sd917;
                5'd13: v = 26'sd458;
                5'd14: v = 26'sd229;
                5'd15: v = 26'sd115;
                5'd16: v = 26'sd57;
                5'd17: v = 26'sd29;
                5'd18: v = 26'sd14;
                5'd19: v = 26'sd7;
                5'd20: v = 26'sd4;
                5'd21: v = 26'sd2;
                5'd22: v = 26'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/accel_tilt_angles.sv -----
// datapath: the pre-rotation register loads at the input transfer, then one
//   register per micro-rotation (rotation stages capped at 24) and one
//   output register
// throughput: one sample per cycle; the whole pipeline advances when the
//   output register is empty or being taken
// reset: valid bits clear asynchronously; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module accel_tilt_angles #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  x_lsb,
    input  wire  [7:0]  x_msb,
    input  wire  [7:0]  y_lsb,
    input  wire  [7:0]  y_msb,
    input  wire  [7:0]  z_lsb,
    input  wire  [7:0]  z_msb,
    output logic        out_valid,
    input  wire         out_ready,
    output logic signed [14:0] angle_xy,
    output logic signed [14:0] angle_xz,
    output logic signed [14:0] angle_yz,
    output logic signed [15:0] pitch,
    output logic signed [15:0] roll
);

    localparam int STAGES = (CORDIC_STEPS < att_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                                : att_pkg::TABLE_LEN;
    localparam int DEPTH   = STAGES + 1;
    localparam int QUARTER = 90 * (1 << ANGLE_FRAC_BITS);

    logic en;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    // pipeline moves when the output stage can take
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // axis values from raw bytes
    logic signed [att_pkg::AXIS_W-1:0] ax, ay, az;
    assign ax = {x_msb, x_lsb[7:6]};
    assign ay = {y_msb, y_lsb[7:6]};
    assign az = {z_msb, z_lsb[7:6]};

    logic signed [att_pkg::ANGLE_W-1:0] a_xy, a_xz, a_yz;

    att_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_xy (
        .clk(clk), .en(en), .num(ay), .den(ax), .angle(a_xy));
    att_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_xz (
        .clk(clk), .en(en), .num(az), .den(ax), .angle(a_xz));
    att_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yz (
        .clk(clk), .en(en), .num(az), .den(ay), .angle(a_yz));

    // valid bits travel with the data
    always_comb
    begin
        vld_next = {vld_reg[DEPTH-2:0], in_valid};
    end

    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    // output register
    logic signed [14:0] xy_reg, xz_reg, yz_reg;
    logic signed [15:0] pitch_reg, roll_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xy_reg    <= a_xy;
            xz_reg    <= a_xz;
            yz_reg    <= a_yz;
            pitch_reg <= 16'(a_yz) - 16'(QUARTER);
            roll_reg  <= 16'(a_xz) - 16'(QUARTER);
        end
    end

    assign out_valid = out_valid_reg;
    assign angle_xy  = xy_reg;
    assign angle_xz  = xz_reg;
    assign angle_yz  = yz_reg;
    assign pitch     = pitch_reg;
    assign roll      = roll_reg;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pitch) && $stable(roll))
        else $error("result changed under stall");

    // pitch tracks angle_yz
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pitch == 16'(angle_yz) - 16'(QUARTER))
        else $error("pitch mismatch");

    // roll tracks angle_xz
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> roll == 16'(angle_xz) - 16'(QUARTER))
        else $error("roll mismatch");

endmodule

`default_nettype wire

// ----- sv/att_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

// pipelined cordic vectoring atan2, one micro-rotation per stage
module att_cordic #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire                                clk,
    input  wire                                en,
    input  wire signed [att_pkg::AXIS_W-1:0]   num,
    input  wire signed [att_pkg::AXIS_W-1:0]   den,
    output logic signed [att_pkg::ANGLE_W-1:0] angle
);

    localparam int STAGES = (CORDIC_STEPS < att_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                                : att_pkg::TABLE_LEN;
    localparam int DROP = att_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int LIM  = 180 * (1 << ANGLE_FRAC_BITS);

    att_pkg::vec_t x_reg [0:STAGES];
    att_pkg::vec_t y_reg [0:STAGES];
    att_pkg::acc_t z_reg [0:STAGES];
    logic          zero_reg [0:STAGES];

    att_pkg::vec_t x_next, y_next;
    att_pkg::acc_t z_next;

    // pre-rotation by 180 degrees for a negative denominator
    always_comb
    begin
        x_next = att_pkg::vec_t'(den) <<< att_pkg::PRE_SHIFT;
        y_next = att_pkg::vec_t'(num) <<< att_pkg::PRE_SHIFT;
        z_next = '0;
        if (den < 0)
        begin
            z_next = (num >= 0) ? att_pkg::acc_t'(180 * (1 << att_pkg::ACC_FRAC))
                                : att_pkg::acc_t'(-180 * (1 << att_pkg::ACC_FRAC));
            x_next = -x_next;
            y_next = -y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (num == 0) && (den == 0);
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + att_pkg::atan_entry(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - att_pkg::atan_entry(5'(i));
                end
            end
        end
    end

    // round half up, clamp, zero case
    att_pkg::acc_t z_rnd;
    att_pkg::acc_t z_q;
    always_comb
    begin
        z_rnd = z_reg[STAGES] + att_pkg::acc_t'(1 << (DROP - 1));
        z_q   = z_rnd >>> DROP;
        if (zero_reg[STAGES])
            angle = '0;
        else if (z_q > att_pkg::acc_t'(LIM))
            angle = att_pkg::ANGLE_W'(LIM);
        else if (z_q < att_pkg::acc_t'(-LIM))
            angle = att_pkg::ANGLE_W'(-LIM);
        else
            angle = z_q[att_pkg::ANGLE_W-1:0];
    end

endmodule

`default_nettype wire

// ----- test/tilt_checker.sv -----
`timescale 1ns / 1ps

module tilt_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_ready,
    input  wire  [7:0] x_lsb,
    input  wire  [7:0] x_msb,
    input  wire  [7:0] y_lsb,
    input  wire  [7:0] y_msb,
    input  wire  [7:0] z_lsb,
    input  wire  [7:0] z_msb,
    input  wire        out_valid,
    input  wire        out_ready,
    input  wire signed [14:0] angle_xy,
    input  wire signed [14:0] angle_xz,
    input  wire signed [14:0] angle_yz,
    input  wire signed [15:0] pitch,
    input  wire signed [15:0] roll,
    output int         fail_count,
    output int         pending,
    output int         result_count
);

    localparam int STEPS     = 16;
    localparam int FRAC_BITS = 6;

    typedef struct packed {
        logic [14:0] xy;
        logic [14:0] xz;
        logic [14:0] yz;
        logic [15:0] pitch;
        logic [15:0] roll;
    } tilt_t;

    tilt_t angle_q[$];

    // atan(2^-i) in 2^-16 degree
    function automatic longint atan_step(input int i);
        longint tab[24];
        begin
            tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                    14668, 7334, 3667, 1833, 917, 458, 229, 115,
                    57, 29, 14, 7, 4, 2, 1, 0};
            return tab[i];
        end
    endfunction

    function automatic longint axis_of(input logic [7:0] lsb, input logic [7:0] msb);
        logic signed [9:0] v;
        begin
            v = {msb, lsb[7:6]};
            return longint'(v);
        end
    endfunction

    // vectoring cordic, angle rounded to 1/64 degree
    function automatic longint vector_angle(input longint num, input longint den);
        longint vx, vy, acc, t, lim;
        int i;
        begin
            if (num == 0 && den == 0)
                return 0;
            vx = den <<< 20;
            vy = num <<< 20;
            acc = 0;
            if (vx < 0)
            begin
                acc = (vy >= 0 ? 180 : -180) * 65536;
                vx = -vx;
                vy = -vy;
            end
            for (i = 0; i < STEPS && i < 24; i++)
            begin
                if (vy > 0)
                begin
                    t = vx + (vy >>> i);
                    vy = vy - (vx >>> i);
                    vx = t;
                    acc += atan_step(i);
                end
                else
                begin
                    t = vx - (vy >>> i);
                    vy = vy + (vx >>> i);
                    vx = t;
                    acc -= atan_step(i);
                end
            end
            acc = (acc + (64'sd1 <<< (15 - FRAC_BITS))) >>> (16 - FRAC_BITS);
            lim = 180 * (1 << FRAC_BITS);
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            return acc;
        end
    endfunction

    function automatic tilt_t predict_tilt(input logic [7:0] xl, xm, yl, ym, zl, zm);
        longint ax, ay, az, a_xy, a_xz, a_yz;
        tilt_t r;
        begin
            ax = axis_of(xl, xm);
            ay = axis_of(yl, ym);
            az = axis_of(zl, zm);
            a_xy = vector_angle(ay, ax);
            a_xz = vector_angle(az, ax);
            a_yz = vector_angle(az, ay);
            r.xy = a_xy[14:0];
            r.xz = a_xz[14:0];
            r.yz = a_yz[14:0];
            r.pitch = 16'(a_yz - 90 * (1 << FRAC_BITS));
            r.roll  = 16'(a_xz - 90 * (1 << FRAC_BITS));
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // allow one lsb of rounding slack
    function automatic bit near(input int got, input int want);
        return (got - want <= 1) && (want - got <= 1);
    endfunction

    initial
    begin
        fail_count = 0;
        result_count = 0;
    end

    assign pending = angle_q.size();

    // watch both channels
    always @(posedge clk)
    begin
        tilt_t w;
        if (rst_n && in_valid && in_ready)
            angle_q.push_back(predict_tilt(x_lsb, x_msb, y_lsb, y_msb, z_lsb, z_msb));
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (angle_q.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                w = angle_q.pop_front();
                if (!near(angle_xy, $signed(w.xy)))
                    report_mismatch("angle_xy", angle_xy, $signed(w.xy));
                if (!near(angle_xz, $signed(w.xz)))
                    report_mismatch("angle_xz", angle_xz, $signed(w.xz));
                if (!near(angle_yz, $signed(w.yz)))
                    report_mismatch("angle_yz", angle_yz, $signed(w.yz));
                if (!near(pitch, $signed(w.pitch)))
                    report_mismatch("pitch", pitch, $signed(w.pitch));
                if (!near(roll, $signed(w.roll)))
                    report_mismatch("roll", roll, $signed(w.roll));
            end
        end
    end

endmodule

// ----- test/tb_accel_tilt_angles.sv -----
`timescale 1ns / 1ps

module tb_accel_tilt_angles;

    localparam int RANDOM_ITEMS = 1130;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk, rst_n;
    logic in_valid, out_ready;
    logic [7:0] x_lsb, x_msb, y_lsb, y_msb, z_lsb, z_msb;
    wire in_ready, out_valid;
    wire signed [14:0] angle_xy, angle_xz, angle_yz;
    wire signed [15:0] pitch, roll;
    int fail_count, pending, result_count;
    int send_idle, recv_idle, hold_off;
    int cycle_count, sent;

    accel_tilt_angles dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .x_lsb(x_lsb), .x_msb(x_msb), .y_lsb(y_lsb), .y_msb(y_msb),
        .z_lsb(z_lsb), .z_msb(z_msb), .out_valid(out_valid), .out_ready(out_ready),
        .angle_xy(angle_xy), .angle_xz(angle_xz), .angle_yz(angle_yz),
        .pitch(pitch), .roll(roll)
    );

    tilt_checker chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .x_lsb(x_lsb), .x_msb(x_msb), .y_lsb(y_lsb), .y_msb(y_msb),
        .z_lsb(z_lsb), .z_msb(z_msb), .out_valid(out_valid), .out_ready(out_ready),
        .angle_xy(angle_xy), .angle_xz(angle_xz), .angle_yz(angle_yz),
        .pitch(pitch), .roll(roll), .fail_count(fail_count), .pending(pending),
        .result_count(result_count)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // timeout guard
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: random stalls plus a long hold-off
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // one transfer on the input channel, with sender idling
    task automatic send_sample(input logic [7:0] xl, xm, yl, ym, zl, zm);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        x_lsb <= xl; x_msb <= xm; y_lsb <= yl;
        y_msb <= ym; z_lsb <= zl; z_msb <= zm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // axis value as msb and lsb bytes, with random don't-care lsb bits
    task automatic send_axes(input int ax, ay, az);
        logic [9:0] vx, vy, vz;
        vx = 10'(ax); vy = 10'(ay); vz = 10'(az);
        send_sample({vx[1:0], 6'($urandom)}, vx[9:2], {vy[1:0], 6'($urandom)}, vy[9:2],
                    {vz[1:0], 6'($urandom)}, vz[9:2]);
    endtask

    initial
    begin
        int i, k;
        int corner[5];
        corner = '{0, 1, -1, 511, -512};
        rst_n = 0;
        in_valid = 0;
        hold_off = 0;
        sent = 0;
        send_idle = 31;
        recv_idle = 78;
        {x_lsb, x_msb, y_lsb, y_msb, z_lsb, z_msb} = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: zeros, axis extremes, zero numerator over negative denominator
        send_axes(0, 0, 0);
        send_axes(-512, 0, 0);
        send_axes(0, -512, 0);
        send_axes(511, 511, 511);
        send_axes(-512, -512, -512);
        send_axes(0, 0, 511);
        send_axes(-1, 0, 0);
        for (i = 0; i < 15; i++)
            send_axes(corner[i % 5], corner[(i / 5 + i) % 5], corner[(i * 3) % 5]);
        send_sample(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_sample(8'h3f, 8'h80, 8'hc0, 8'h7f, 8'h00, 8'h00);

        // random phases
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                send_idle = 78;
                recv_idle = 31;
            end
            if (i == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
                hold_off <= 200;
            end
            k = $urandom_range(9);
            if (k < 6)
                send_sample(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom));
            else if (k < 8)
                send_axes(corner[$urandom_range(4)], corner[$urandom_range(4)],
                          corner[$urandom_range(4)]);
            else
                send_axes($urandom_range(8) - 4, $urandom_range(8) - 4,
                          $urandom_range(8) - 4);
        end
        in_valid <= 0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d samples, checked %0d angle sets across three idling phases",
                 sent, result_count);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
